// ----- rtl/emg_pkg.sv -----
// -----------------------------------------------------------------------------
// emg_pkg
// Shared types and constants of the envelope matching gain designer: sizes,
// fixed-point limits, command and result codes, beat payloads, port structs.
// -----------------------------------------------------------------------------
package emg_pkg;

   localparam int NUM_BINS   = 512;
   localparam int NUM_BANDS  = 32;
   localparam int PER_BAND   = (NUM_BINS / NUM_BANDS < 1) ? 1 : NUM_BINS / NUM_BANDS;
   localparam int NUM_PLACED = (NUM_BANDS < NUM_BINS) ? NUM_BANDS : NUM_BINS;

   localparam int BIN_AW  = $clog2(NUM_BINS);
   localparam int BAND_AW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
   localparam int RUN_W   = (PER_BAND > 1) ? $clog2(PER_BAND) : 1;

   // beat field widths
   localparam int CMD_W     = 2;
   localparam int BAND_FW   = 5;
   localparam int LEVEL_W   = 32;
   localparam int BIN_FW    = 9;
   localparam int KIND_W    = 2;
   localparam int GAIN_W    = 23;

   // ratio divider: numerator is target * 2^16 + source / 2
   localparam int DIV_NUM_W  = 49;
   localparam int DIV_STEP_W = 6;

   // blend: floor(s / 10) as (s * RECIP_10) >> RECIP_SHIFT, exact for 32-bit s
   localparam int BLEND_SUM_W = 27;
   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = 35;
   localparam logic [RECIP_W-1:0] RECIP_10 = 32'hCCCC_CCCD;

   localparam logic [LEVEL_W-1:0] UNITY_LEVEL = 32'd65536;
   localparam logic [GAIN_W-1:0]  UNITY_GAIN  = 23'd65536;
   localparam logic [GAIN_W-1:0]  GAIN_MIN    = 23'd655;
   localparam logic [GAIN_W-1:0]  GAIN_MAX    = 23'd6553600;

   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

   localparam logic [KIND_W-1:0] KIND_WRITE_ACK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COMPUTED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ_DATA = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [BAND_FW-1:0] band;
      logic [LEVEL_W-1:0] source_level;
      logic [LEVEL_W-1:0] target_level;
      logic [BIN_FW-1:0]  bin;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [GAIN_W-1:0] gain;
   } rsp_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] src;
      logic [LEVEL_W-1:0] tgt;
   } env_pair_type;

   typedef struct packed {
      logic               en;
      logic [BAND_AW-1:0] addr;
      env_pair_type       data;
   } env_wr_type;

   typedef struct packed {
      logic              en;
      logic [BIN_AW-1:0] addr;
      logic [GAIN_W-1:0] data;
   } gain_wr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_ENV_RD,
      ST_ENV_WAIT,
      ST_DIV,
      ST_FWD_CALC,
      ST_FWD_WR,
      ST_BWD_RD,
      ST_BWD_WAIT,
      ST_BWD_WR
   } state_type;

endpackage

// ----- rtl/envelope_match_gain_design.sv -----
// -----------------------------------------------------------------------------
// envelope_match_gain_design
// Spectral envelope matching gain designer: stores per-band source and target
// levels, designs smoothed per-bin gains on command, and serves bin reads.
//
//   channel  ports                        direction  payload
//   req      req_valid/req_stall/req_data  in         emg_pkg::req_type
//   rsp      rsp_valid/rsp_stall/rsp_data  out        emg_pkg::rsp_type
//
// A level write answers in the cycle after it is accepted; a gain read first
// waits in ST_RD_WAIT for the registered gain store read. A compute reads the
// levels of each band (ST_ENV_RD, ST_ENV_WAIT), runs 49 divider steps and
// writes the band's bins forward; a backward read-modify-write pass follows.
// Reset is synchronous; levels and gains read unity until first written.
// req_stall is high while an item is in flight or the result beat is stalled.
// -----------------------------------------------------------------------------
module envelope_match_gain_design (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  emg_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output emg_pkg::rsp_type   rsp_data
);

   localparam logic [emg_pkg::BIN_AW-1:0]  BIN_LAST  =
      emg_pkg::BIN_AW'(emg_pkg::NUM_BINS - 1);
   localparam logic [emg_pkg::BAND_AW-1:0] BAND_LAST =
      emg_pkg::BAND_AW'(emg_pkg::NUM_PLACED - 1);
   localparam logic [emg_pkg::RUN_W-1:0]   RUN_LAST  =
      emg_pkg::RUN_W'(emg_pkg::PER_BAND - 1);

   emg_pkg::state_type              state_ff, state_in;
   logic [emg_pkg::BIN_AW-1:0]      bin_ff, bin_in;
   logic [emg_pkg::BAND_AW-1:0]     band_ff, band_in;
   logic [emg_pkg::RUN_W-1:0]       run_ff, run_in;
   logic [emg_pkg::GAIN_W-1:0]      prev_ff, prev_in;
   logic [emg_pkg::GAIN_W-1:0]      cur_ff, cur_in;
   logic                            oob_ff, oob_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   emg_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   emg_pkg::env_wr_type             env_wr;
   emg_pkg::env_pair_type           env_rd_data;
   emg_pkg::gain_wr_type            gain_wr;
   logic [emg_pkg::BIN_AW-1:0]      gain_rd_addr;
   logic [emg_pkg::GAIN_W-1:0]      gain_rd_data;
   logic                            div_start;
   logic                            div_done;
   logic [emg_pkg::GAIN_W-1:0]      div_gain;
   logic [emg_pkg::GAIN_W-1:0]      blend_cur;
   logic [emg_pkg::GAIN_W-1:0]      blend_q;

   logic                            out_free;
   logic                            accept;
   logic [31:0]                     band_ext;
   logic [31:0]                     bin_ext;
   logic                            band_ok;
   logic                            bin_ok;

   assign band_ext = 32'(req_data.band);
   assign bin_ext  = 32'(req_data.bin);
   assign band_ok  = band_ext < 32'(emg_pkg::NUM_BANDS);
   assign bin_ok   = bin_ext < 32'(emg_pkg::NUM_BINS);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = (state_ff == emg_pkg::ST_IDLE) && req_valid && out_free;

   emg_env_mem u_env_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (env_wr),
      .rd_addr (band_ff),
      .rd_data (env_rd_data)
   );

   emg_gain_mem u_gain_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (gain_wr),
      .rd_addr (gain_rd_addr),
      .rd_data (gain_rd_data)
   );

   emg_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .levels (env_rd_data),
      .done   (div_done),
      .gain   (div_gain)
   );

   assign blend_cur = (state_ff == emg_pkg::ST_BWD_WAIT) ? gain_rd_data : cur_ff;

   emg_blend u_blend (
      .clock  (clock),
      .prev   (prev_ff),
      .cur    (blend_cur),
      .result (blend_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= emg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      band_ff     <= band_in;
      run_ff      <= run_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      oob_ff      <= oob_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      band_in      = band_ff;
      run_in       = run_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      oob_in       = oob_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      req_stall    = 1'b1;
      div_start    = 1'b0;
      gain_rd_addr = bin_ff;
      env_wr.en    = 1'b0;
      env_wr.addr  = band_ext[emg_pkg::BAND_AW-1:0];
      env_wr.data.src = req_data.source_level;
      env_wr.data.tgt = req_data.target_level;
      gain_wr.en   = 1'b0;
      gain_wr.addr = bin_ff;
      gain_wr.data = blend_q;

      unique case (state_ff)
         emg_pkg::ST_IDLE: begin
            req_stall    = !out_free;
            gain_rd_addr = bin_ext[emg_pkg::BIN_AW-1:0];
            if (accept) begin
               unique case (req_data.cmd)
                  emg_pkg::CMD_WRITE: begin
                     env_wr.en        = band_ok;
                     rsp_valid_in     = 1'b1;
                     rsp_data_in.kind = emg_pkg::KIND_WRITE_ACK;
                     rsp_data_in.gain = '0;
                  end
                  emg_pkg::CMD_COMPUTE: begin
                     bin_in   = '0;
                     band_in  = '0;
                     run_in   = '0;
                     state_in = emg_pkg::ST_ENV_RD;
                  end
                  emg_pkg::CMD_READ: begin
                     oob_in   = !bin_ok;
                     state_in = emg_pkg::ST_RD_WAIT;
                  end
                  default: begin
                     // unused command: drop without a result
                  end
               endcase
            end
         end
         emg_pkg::ST_RD_WAIT: begin
            rsp_valid_in     = 1'b1;
            rsp_data_in.kind = emg_pkg::KIND_READ_DATA;
            rsp_data_in.gain = oob_ff ? '0 : gain_rd_data;
            state_in         = emg_pkg::ST_IDLE;
         end
         emg_pkg::ST_ENV_RD: begin
            state_in = emg_pkg::ST_ENV_WAIT;
         end
         emg_pkg::ST_ENV_WAIT: begin
            div_start = 1'b1;
            state_in  = emg_pkg::ST_DIV;
         end
         emg_pkg::ST_DIV: begin
            if (div_done) begin
               cur_in = div_gain;
               // blend of a value with itself is the value: seed bin 0 so
               if (bin_ff == '0) begin
                  prev_in = div_gain;
               end
               state_in = emg_pkg::ST_FWD_CALC;
            end
         end
         emg_pkg::ST_FWD_CALC: begin
            state_in = emg_pkg::ST_FWD_WR;
         end
         emg_pkg::ST_FWD_WR: begin
            gain_wr.en = 1'b1;
            prev_in    = blend_q;
            if (bin_ff == BIN_LAST) begin
               bin_in   = bin_ff - 1'b1;
               state_in = emg_pkg::ST_BWD_RD;
            end else begin
               bin_in = bin_ff + 1'b1;
               if (run_ff == RUN_LAST) begin
                  run_in = '0;
                  if (band_ff == BAND_LAST) begin
                     // past the last band: fill with unity
                     cur_in   = emg_pkg::UNITY_GAIN;
                     state_in = emg_pkg::ST_FWD_CALC;
                  end else begin
                     band_in  = band_ff + 1'b1;
                     state_in = emg_pkg::ST_ENV_RD;
                  end
               end else begin
                  run_in   = run_ff + 1'b1;
                  state_in = emg_pkg::ST_FWD_CALC;
               end
            end
         end
         emg_pkg::ST_BWD_RD: begin
            state_in = emg_pkg::ST_BWD_WAIT;
         end
         emg_pkg::ST_BWD_WAIT: begin
            state_in = emg_pkg::ST_BWD_WR;
         end
         emg_pkg::ST_BWD_WR: begin
            gain_wr.en = 1'b1;
            prev_in    = blend_q;
            if (bin_ff == '0) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in.kind = emg_pkg::KIND_COMPUTED;
               rsp_data_in.gain = '0;
               state_in         = emg_pkg::ST_IDLE;
            end else begin
               bin_in   = bin_ff - 1'b1;
               state_in = emg_pkg::ST_BWD_RD;
            end
         end
         default: begin
            state_in = emg_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/emg_env_mem.sv -----
// -----------------------------------------------------------------------------
// emg_env_mem
// Source/target envelope store, one entry per band. Synchronous read, data
// registered; a per-entry valid bit makes unwritten entries read unity.
// -----------------------------------------------------------------------------
module emg_env_mem (
   input  logic                         clock,
   input  logic                         reset,
   input  emg_pkg::env_wr_type          wr,
   input  logic [emg_pkg::BAND_AW-1:0]  rd_addr,
   output emg_pkg::env_pair_type        rd_data
);

   emg_pkg::env_pair_type               mem [emg_pkg::NUM_BANDS];
   logic [emg_pkg::NUM_BANDS-1:0]       valid_ff;
   emg_pkg::env_pair_type               rd_q_ff;
   logic                                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      if (rd_valid_ff) begin
         rd_data = rd_q_ff;
      end else begin
         rd_data.src = emg_pkg::UNITY_LEVEL;
         rd_data.tgt = emg_pkg::UNITY_LEVEL;
      end
   end

endmodule

// ----- rtl/emg_gain_mem.sv -----
// -----------------------------------------------------------------------------
// emg_gain_mem
// Per-bin gain store. One write port, one read port with the read data
// registered. Until the first gain design pass writes it, every bin reads unity.
// -----------------------------------------------------------------------------
module emg_gain_mem (
   input  logic                         clock,
   input  logic                         reset,
   input  emg_pkg::gain_wr_type         wr,
   input  logic [emg_pkg::BIN_AW-1:0]   rd_addr,
   output logic [emg_pkg::GAIN_W-1:0]   rd_data
);

   logic [emg_pkg::GAIN_W-1:0] mem [emg_pkg::NUM_BINS];
   logic [emg_pkg::GAIN_W-1:0] rd_q_ff;
   logic                       filled_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // a design pass writes every bin, so one flag covers the whole store
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
      end else if (wr.en) begin
         filled_ff <= 1'b1;
      end
   end

   assign rd_data = filled_ff ? rd_q_ff : emg_pkg::UNITY_GAIN;

endmodule

// ----- rtl/emg_divider.sv -----
// -----------------------------------------------------------------------------
// emg_divider
// Band gain unit: rounded target/source ratio in Q7.16 by restoring division,
// one quotient bit per cycle, then clamped to the gain range.
// -----------------------------------------------------------------------------
module emg_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  emg_pkg::env_pair_type         levels,
   output logic                          done,
   output logic [emg_pkg::GAIN_W-1:0]    gain
);

   localparam logic [emg_pkg::DIV_STEP_W-1:0] STEP_LAST =
      emg_pkg::DIV_STEP_W'(emg_pkg::DIV_NUM_W - 1);

   logic                               busy_ff;
   logic                               done_ff;
   logic [emg_pkg::DIV_STEP_W-1:0]     step_ff;
   logic [emg_pkg::LEVEL_W-1:0]        src_ff;
   logic                               zero_ff;
   logic [emg_pkg::DIV_NUM_W-1:0]      num_ff;
   logic [emg_pkg::LEVEL_W-1:0]        rem_ff;
   logic [emg_pkg::DIV_NUM_W-1:0]      quo_ff;

   logic [emg_pkg::LEVEL_W:0]          rem_shift;
   logic [emg_pkg::LEVEL_W:0]          rem_diff;
   logic                               fits;

   assign rem_shift = {rem_ff, num_ff[emg_pkg::DIV_NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, src_ff};
   assign fits      = rem_shift >= {1'b0, src_ff};

   always_ff @(posedge clock) begin
      if (start) begin
         src_ff  <= levels.src;
         zero_ff <= (levels.src == '0);
         num_ff  <= {1'b0, levels.tgt, 16'b0}
                    + emg_pkg::DIV_NUM_W'(levels.src >> 1);
         rem_ff  <= '0;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? rem_diff[emg_pkg::LEVEL_W-1:0]
                        : rem_shift[emg_pkg::LEVEL_W-1:0];
         quo_ff <= {quo_ff[emg_pkg::DIV_NUM_W-2:0], fits};
         num_ff <= num_ff << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      priority if (zero_ff) begin
         gain = emg_pkg::UNITY_GAIN;
      end else if (quo_ff > emg_pkg::DIV_NUM_W'(emg_pkg::GAIN_MAX)) begin
         gain = emg_pkg::GAIN_MAX;
      end else if (quo_ff < emg_pkg::DIV_NUM_W'(emg_pkg::GAIN_MIN)) begin
         gain = emg_pkg::GAIN_MIN;
      end else begin
         gain = quo_ff[emg_pkg::GAIN_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

// ----- rtl/emg_blend.sv -----
// -----------------------------------------------------------------------------
// emg_blend
// One-pole smoothing step: floor((3*prev + 7*cur + 5) / 10), with the divide
// done as a reciprocal multiply. Result is registered.
// -----------------------------------------------------------------------------
module emg_blend (
   input  logic                          clock,
   input  logic [emg_pkg::GAIN_W-1:0]    prev,
   input  logic [emg_pkg::GAIN_W-1:0]    cur,
   output logic [emg_pkg::GAIN_W-1:0]    result
);

   localparam int PROD_W = emg_pkg::BLEND_SUM_W + emg_pkg::RECIP_W;

   logic [emg_pkg::BLEND_SUM_W-1:0] prev_w;
   logic [emg_pkg::BLEND_SUM_W-1:0] cur_w;
   logic [emg_pkg::BLEND_SUM_W-1:0] sum;
   logic [PROD_W-1:0]               prod;
   logic [emg_pkg::GAIN_W-1:0]      result_ff;

   assign prev_w = emg_pkg::BLEND_SUM_W'(prev);
   assign cur_w  = emg_pkg::BLEND_SUM_W'(cur);
   assign sum    = (prev_w << 1) + prev_w + (cur_w << 3) - cur_w
                   + emg_pkg::BLEND_SUM_W'(5);
   assign prod   = PROD_W'(sum) * PROD_W'(emg_pkg::RECIP_10);

   always_ff @(posedge clock) begin
      result_ff <= prod[emg_pkg::RECIP_SHIFT +: emg_pkg::GAIN_W];
   end

   assign result = result_ff;

endmodule
